FILE: sv/bmhq_pkg.sv
// bmhq_pkg: shared types, widths and codes of the binary min-heap queue
// no dependencies; every other file of the block imports it

package bmhq_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 11;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [OCC_W-1:0]        occ_t;

  // operation codes of a request transaction
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  // completion codes of a response transaction
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

FILE: sv/bmhq_if.sv
// bmhq_req_if / bmhq_rsp_if: valid/ready channels for requests and responses
// depends on bmhq_pkg

interface bmhq_req_if import bmhq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface bmhq_rsp_if import bmhq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KEY_W-1:0]    popped_key;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output popped_key, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input popped_key, input status, input occupancy,
                  output ready);
endinterface

FILE: sv/bmhq_ram.sv
// bmhq_ram: key store, one write port and one read port with registered data
// depends on bmhq_pkg

module bmhq_ram import bmhq_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  key_t          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output key_t          rdata_o
);

  key_t mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: sv/binary_min_heap_queue_core.sv
// Binary min-heap priority queue of signed 32-bit keys. A push (cmd 0) adds a
// key, a pop (cmd 1) returns and removes the smallest one; each request gives one
// response with the popped key, a status (done, full, empty) and the occupancy
// after the operation. Keys live in a single-read-port RAM, so the sequencer
// walks the heap one level at a time with one shared comparator, paced by the
// one RAM read per cycle. A push climbs level by level, reading the parent and
// moving it down while it is larger; a pop reads the root and the last entry,
// then sinks that entry through the two-child, lone-child or leaf case. A pop of
// the last key and refused operations skip the walk. A stalled response holds
// the sequencer until the output register is free. The next request is taken
// while the previous response still waits at the output.
// depends on bmhq_pkg, bmhq_if, bmhq_ram

module binary_min_heap_queue_core import bmhq_pkg::*; #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmhq_req_if.sink  req_i,
  bmhq_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_POP_ROOT,
    S_POP_LAST,
    S_POP_VAL,
    S_DN_CHK,
    S_DN_RL,
    S_DN_RR,
    S_DN_CMP,
    S_DN_LONE,
    S_WR_VAL,
    S_DONE
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] pick_idx_q, pick_idx_d;
  key_t          val_q, val_d;
  key_t          left_q, left_d;
  key_t          pick_key_q, pick_key_d;
  key_t          popped_q, popped_d;
  status_e       status_q, status_d;
  key_t          out_key_q, out_key_d;
  status_e       out_status_q, out_status_d;
  occ_t          out_occ_q, out_occ_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  key_t          ram_wdata, ram_rdata;

  key_t          cmp_a, cmp_b;
  logic          cmp_gt;

  logic [IW-1:0] lc_w, rc_w, n_w;
  logic [AW-1:0] parent;
  logic          accept, out_free;

  bmhq_ram #(.DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // heap index arithmetic around the current position
  assign lc_w   = IW'({pos_q, 1'b1});
  assign rc_w   = lc_w + 1'b1;
  assign n_w    = IW'(count_q);
  assign parent = AW'((pos_q - 1'b1) >> 1);

  // handshakes
  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.popped_key = out_key_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.occupancy  = out_occ_q;

  // shared signed comparator, operands chosen by state
  always_comb begin
    cmp_a = val_q;
    cmp_b = ram_rdata;
    unique case (state_q)
      S_UP_CMP: begin
        cmp_a = ram_rdata;
        cmp_b = val_q;
      end
      S_DN_RR: begin
        cmp_a = ram_rdata;
        cmp_b = left_q;
      end
      S_DN_CMP: begin
        cmp_a = val_q;
        cmp_b = pick_key_q;
      end
      default: begin
        cmp_a = val_q;
        cmp_b = ram_rdata;
      end
    endcase
  end

  assign cmp_gt = (cmp_a > cmp_b);

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    pos_d        = pos_q;
    pick_idx_d   = pick_idx_q;
    val_d        = val_q;
    left_d       = left_q;
    pick_key_d   = pick_key_q;
    popped_d     = popped_q;
    status_d     = status_q;
    out_key_d    = out_key_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    ram_we       = 1'b0;
    ram_waddr    = pos_q;
    ram_wdata    = val_q;
    ram_re       = 1'b0;
    ram_raddr    = pos_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          popped_d = '0;
          status_d = ST_DONE;
          if (req_i.cmd == CMD_PUSH) begin
            if (count_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              val_d   = req_i.key;
              pos_d   = AW'(count_q);
              count_d = count_q + 1'b1;
              state_d = S_UP_CHK;
            end
          end else if (count_q == '0) begin
            status_d = ST_EMPTY;
            state_d  = S_DONE;
          end else begin
            state_d = S_POP_ROOT;
          end
        end
      end

      // sift up: fetch the parent unless at the root
      S_UP_CHK: begin
        if (pos_q == '0) begin
          state_d = S_WR_VAL;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = parent;
          state_d   = S_UP_CMP;
        end
      end

      // parent larger: move it down into the hole
      S_UP_CMP: begin
        if (cmp_gt) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_d     = parent;
          state_d   = S_UP_CHK;
        end else begin
          state_d = S_WR_VAL;
        end
      end

      S_POP_ROOT: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_d   = S_POP_LAST;
      end

      // root arrives; fetch the last entry unless the heap empties
      S_POP_LAST: begin
        popped_d = ram_rdata;
        count_d  = count_q - 1'b1;
        if (count_q == CW'(1)) begin
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(count_q - 1'b1);
          state_d   = S_POP_VAL;
        end
      end

      S_POP_VAL: begin
        val_d   = ram_rdata;
        pos_d   = '0;
        state_d = S_DN_CHK;
      end

      // sift down: decide between two children, a lone child or a leaf
      S_DN_CHK: begin
        ram_raddr = AW'(lc_w);
        if (rc_w < n_w) begin
          ram_re  = 1'b1;
          state_d = S_DN_RL;
        end else if (rc_w == n_w) begin
          ram_re  = 1'b1;
          state_d = S_DN_LONE;
        end else begin
          state_d = S_WR_VAL;
        end
      end

      S_DN_RL: begin
        left_d    = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = AW'(rc_w);
        state_d   = S_DN_RR;
      end

      // smaller child, the right one on a tie
      S_DN_RR: begin
        if (cmp_gt) begin
          pick_key_d = left_q;
          pick_idx_d = AW'(lc_w);
        end else begin
          pick_key_d = ram_rdata;
          pick_idx_d = AW'(rc_w);
        end
        state_d = S_DN_CMP;
      end

      S_DN_CMP: begin
        if (cmp_gt) begin
          ram_we    = 1'b1;
          ram_wdata = pick_key_q;
          pos_d     = pick_idx_q;
          state_d   = S_DN_CHK;
        end else begin
          state_d = S_WR_VAL;
        end
      end

      S_DN_LONE: begin
        if (cmp_gt) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_d     = AW'(lc_w);
        end
        state_d = S_WR_VAL;
      end

      S_WR_VAL: begin
        ram_we  = 1'b1;
        state_d = S_DONE;
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_key_d    = popped_q;
          out_status_d = status_q;
          out_occ_d    = OCC_W'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath and output payload
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    pick_idx_q   <= pick_idx_d;
    val_q        <= val_d;
    left_q       <= left_d;
    pick_key_q   <= pick_key_d;
    popped_q     <= popped_d;
    status_q     <= status_d;
    out_key_q    <= out_key_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

endmodule

FILE: sv/bmhq_checker.sv
// bmhq_checker: port-level assertions on the heap queue, bound to the top level
// depends on bmhq_pkg and binary_min_heap_queue_core

module bmhq_checker import bmhq_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [KEY_W-1:0]    popped_key_i,
  input logic [STATUS_W-1:0] status_i,
  input logic [OCC_W-1:0]    occupancy_i
);

  // a stalled response holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(popped_key_i) && $stable(status_i) && $stable(occupancy_i))
    else $error("response payload changed while stalled");

  // the block is not ready in the cycle after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while previous one in flight");

  // only defined status codes leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (status_i == ST_DONE || status_i == ST_FULL ||
                     status_i == ST_EMPTY))
    else $error("undefined status code");

  // a refused operation carries a zero key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != ST_DONE |-> popped_key_i == '0)
    else $error("refused operation returned a key");

  // an empty refusal reports an empty heap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_EMPTY |-> occupancy_i == '0)
    else $error("empty status with nonzero occupancy");

endmodule

bind binary_min_heap_queue_core bmhq_checker u_bmhq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .popped_key_i (rsp_o.popped_key),
  .status_i     (rsp_o.status),
  .occupancy_i  (rsp_o.occupancy)
);

FILE: tb/sv/tb_top.sv
// tb_top: self-checking testbench of binary_min_heap_queue_core, with a heap predictor
// inside a small scoreboard class; depends on bmhq_pkg, bmhq_if and the core's RTL files

module tb_top;
  import bmhq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY  = 1024;
  localparam int unsigned MAX_SHOWN = 10;
  localparam int unsigned QUIET_OCC = CAPACITY - 64;
  localparam int unsigned DRAIN_OPS = 16;

  // one expected response transaction
  typedef struct packed {
    key_t    popped;
    status_e status;
    occ_t    occupancy;
  } heap_result_t;

  // heap predictor plus the queue of responses still owed by the block
  class heap_scoreboard;
    key_t         heap_keys [CAPACITY];
    int unsigned  key_count;
    heap_result_t owed_results[$];
    int unsigned  mismatches;
    int unsigned  push_done, pop_done, full_refused, empty_refused, peak_count;

    function new();
      key_count     = 0;
      mismatches    = 0;
      push_done     = 0;
      pop_done      = 0;
      full_refused  = 0;
      empty_refused = 0;
      peak_count    = 0;
    endfunction

    // apply one operation to the predicted heap and return the response it owes
    function heap_result_t predict_heap_op(cmd_e op, key_t new_key);
      heap_result_t res;
      key_t         moving;
      int unsigned  pos, parent, lc, pick;
      res.popped = '0;
      res.status = ST_DONE;
      if (op == CMD_PUSH) begin
        if (key_count >= CAPACITY) begin
          res.status = ST_FULL;
          full_refused++;
        end else begin
          // append, then climb while the parent is strictly larger
          pos = key_count;
          heap_keys[pos] = new_key;
          key_count++;
          moving = new_key;
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!(heap_keys[parent] > moving)) break;
            heap_keys[pos]    = heap_keys[parent];
            heap_keys[parent] = moving;
            pos = parent;
          end
          push_done++;
        end
      end else begin
        if (key_count == 0) begin
          res.status = ST_EMPTY;
          empty_refused++;
        end else begin
          res.popped   = heap_keys[0];
          heap_keys[0] = heap_keys[key_count - 1];
          key_count--;
          pop_done++;
          // sink the new root; right child wins a tie, lone last child checked once
          if (key_count >= 2) begin
            moving = heap_keys[0];
            pos = 0;
            lc  = 1;
            while (lc + 1 < key_count) begin
              pick = (heap_keys[lc + 1] > heap_keys[lc]) ? lc : lc + 1;
              if (!(moving > heap_keys[pick])) break;
              heap_keys[pos]  = heap_keys[pick];
              heap_keys[pick] = moving;
              pos = pick;
              lc  = 2 * pos + 1;
            end
            if (lc + 1 == key_count && moving > heap_keys[lc]) begin
              heap_keys[pos] = heap_keys[lc];
              heap_keys[lc]  = moving;
            end
          end
        end
      end
      if (key_count > peak_count) peak_count = key_count;
      res.occupancy = occ_t'(key_count);
      return res;
    endfunction

    function void note_request(cmd_e op, key_t new_key);
      owed_results.push_back(predict_heap_op(op, new_key));
    endfunction

    function void check_response(key_t popped, status_e status, occ_t occupancy);
      heap_result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("[%0t] unexpected response: key %0d status %s occupancy %0d",
                   $realtime, popped, status.name(), occupancy);
        return;
      end
      want = owed_results.pop_front();
      if (want.popped !== popped || want.status !== status ||
          want.occupancy !== occupancy) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display({"[%0t] response mismatch: want key %0d status %s occ %0d,",
                    " got key %0d status %s occ %0d"},
                   $realtime, want.popped, want.status.name(), want.occupancy,
                   popped, status.name(), occupancy);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   quiet;

  bmhq_req_if req_if ();
  bmhq_rsp_if rsp_if ();

  heap_scoreboard sb;

  binary_min_heap_queue_core #(
    .CAPACITY (CAPACITY)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(64'd10_000_000);
    $display("FAILURE");
    $finish;
  end

  // some small or tied keys, sometimes extremes, mostly any 32-bit pattern
  function automatic key_t draw_key();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        case ($urandom_range(0, 5))
          0:       return key_t'(32'h8000_0000);
          1:       return key_t'(32'h7FFF_FFFF);
          2:       return key_t'(32'h8000_0001);
          3:       return key_t'(32'h7FFF_FFFE);
          4:       return key_t'(32'hFFFF_FFFF);
          default: return key_t'(0);
        endcase
      end
      1, 2, 3: return key_t'($signed($urandom_range(0, 8)) - 4);
      default: return key_t'($urandom);
    endcase
  endfunction

  // present one request transaction and hold it until accepted
  task automatic run_op(cmd_e op, key_t new_key);
    req_if.valid <= 1'b1;
    req_if.cmd   <= op;
    req_if.key   <= (op == CMD_PUSH) ? new_key : key_t'($urandom);
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(op, new_key);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // response side: check each accepted transaction, stall in random bursts
  initial begin : rsp_side
    int unsigned stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_response(key_t'(rsp_if.popped_key), status_e'(rsp_if.status),
                          rsp_if.occupancy);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // request side and end of run
  initial begin : req_side
    int unsigned guard;
    sb = new();
    quiet = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.cmd   = CMD_PUSH;
    req_if.key   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pops, pop of the only key, extremes, ties, lone last child
    run_op(CMD_POP,  key_t'(0));
    run_op(CMD_PUSH, key_t'(7));
    run_op(CMD_POP,  key_t'(0));
    run_op(CMD_POP,  key_t'(32'hFFFF_FFFF));
    run_op(CMD_PUSH, key_t'(32'h7FFF_FFFF));
    run_op(CMD_PUSH, key_t'(32'h8000_0000));
    run_op(CMD_PUSH, key_t'(0));
    run_op(CMD_PUSH, key_t'(-1));
    run_op(CMD_PUSH, key_t'(5));
    run_op(CMD_PUSH, key_t'(5));
    run_op(CMD_PUSH, key_t'(5));
    run_op(CMD_PUSH, key_t'(3));
    run_op(CMD_PUSH, key_t'(-1));
    repeat (9) run_op(CMD_POP, key_t'(0));
    run_op(CMD_POP,  key_t'(0));

    // random fill: pushes with rare pops until full, then a few refused pushes
    while (sb.key_count < CAPACITY || sb.full_refused < 8) begin
      if (sb.key_count >= QUIET_OCC) quiet = 1'b1;
      if ($urandom_range(0, 127) != 0) run_op(CMD_PUSH, draw_key());
      else run_op(CMD_POP, key_t'(0));
    end

    // deep pops from a full heap, back to back
    quiet = 1'b1;
    repeat (DRAIN_OPS) run_op(CMD_POP, key_t'(0));
    req_if.valid <= 1'b0;

    // let outstanding responses arrive, then allow for the longest operation
    guard = 0;
    while (sb.owed_results.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (64) @(posedge clk_i);
    if (sb.owed_results.size() != 0) begin
      $display("%0d responses never arrived", sb.owed_results.size());
      sb.mismatches++;
    end

    $display("pushes %0d, pops %0d, refused full pushes %0d, refused empty pops %0d",
             sb.push_done, sb.pop_done, sb.full_refused, sb.empty_refused);
    $display("peak occupancy %0d of %0d, mismatches %0d",
             sb.peak_count, CAPACITY, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/bmhq_pkg.sv
sv/bmhq_if.sv
sv/bmhq_ram.sv
sv/binary_min_heap_queue_core.sv
sv/bmhq_checker.sv
tb/sv/tb_top.sv
